FILE: rtl/rnc_pkg.sv
// ----------------------------------------------------------------------------
// rnc_pkg: shared constants and types
// Field widths, command and register codes, and the records that travel
// along the row of cluster cells.
// ----------------------------------------------------------------------------
package rnc_pkg;

  localparam int unsigned MAX_POINTS_DEF   = 1024;
  localparam int unsigned MAX_CLUSTERS_DEF = 16;

  localparam int unsigned CRD_W  = 15;  // coordinate width
  localparam int unsigned TYP_W  = 4;   // cluster type width
  localparam int unsigned QIX_W  = 10;  // query index width
  localparam int unsigned CNT_W  = 11;  // neighbor count width
  localparam int unsigned D2_W   = 31;  // squared distance width
  localparam int unsigned SQ_W   = 30;  // one squared coordinate delta
  localparam int unsigned ROOT_W = 24;  // Q.8 root width
  localparam int unsigned NCL_W  = 5;   // num_clusters register width
  localparam int unsigned RAD_W  = 15;  // radius register width
  localparam int unsigned PNT_W  = 2 * CRD_W + TYP_W;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic CFG_NUM_CLUSTERS = 1'b0;
  localparam logic CFG_RADIUS       = 1'b1;

  // one candidate point moving down the row
  typedef struct packed {
    logic             vld;
    logic [TYP_W-1:0] typ;
    logic [D2_W-1:0]  d2;
    logic             near;
  } tok_t;

  // per-cluster accumulator
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [D2_W-1:0]  mind;
    logic             fnd;
  } acc_t;

  // row control
  typedef struct packed {
    logic clr;
    logic shift;
  } ctl_t;

  typedef struct packed {
    logic [TYP_W-1:0]  cluster;
    logic [CNT_W-1:0]  neighbor_count;
    logic [D2_W-1:0]   min_dist2;
    logic [ROOT_W-1:0] min_dist;
    logic              found;
    logic              error;
    logic              last;
  } res_t;

endpackage

FILE: rtl/rnc_if.sv
// ----------------------------------------------------------------------------
// rnc_if: request and result channels
// Valid/ready channels carrying one request or one result per transfer.
// ----------------------------------------------------------------------------
interface rnc_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [rnc_pkg::CRD_W-1:0]   point_x;
  logic [rnc_pkg::CRD_W-1:0]   point_y;
  logic [rnc_pkg::TYP_W-1:0]   point_cluster;
  logic [rnc_pkg::QIX_W-1:0]   query_index;

  modport source (output valid, func, point_x, point_y, point_cluster, query_index,
                  input ready);
  modport sink (input valid, func, point_x, point_y, point_cluster, query_index,
                output ready);
endinterface

interface rnc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rnc_pkg::TYP_W-1:0]   cluster;
  logic [rnc_pkg::CNT_W-1:0]   neighbor_count;
  logic [rnc_pkg::D2_W-1:0]    min_dist2;
  logic [rnc_pkg::ROOT_W-1:0]  min_dist;
  logic                        found;
  logic                        error;
  logic                        last;

  modport source (output valid, cluster, neighbor_count, min_dist2, min_dist, found,
                  error, last, input ready);
  modport sink (input valid, cluster, neighbor_count, min_dist2, min_dist, found,
                error, last, output ready);
endinterface

FILE: rtl/radius_neighbor_count_nearest_unit.sv
// ----------------------------------------------------------------------------
// radius_neighbor_count_nearest_unit: neighbor count and nearest distance
// Point store with per-cluster radius count, minimum squared distance and
// its Q.8 square root, computed by a row of cluster cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one request: load a point, query a stored point, or clear
//   the store. out_res returns results; cfg_we/cfg_idx/cfg_wdata set
//   num_clusters (index 0) and radius (index 1); write these only while the
//   block is idle, a rule the block itself does not enforce. A load into a
//   full store is dropped. A query whose index is not below the point count
//   returns one result with error and last set, in the cycle after acceptance.
//   A good query reads the origin, then streams every stored point from the
//   RAM, one per cycle, through the delta-square and compare stages into the
//   row of cells; each cell owns one cluster type. After the row drains,
//   cells shift their totals to the head one at a time; each total goes
//   through a root extraction before it is presented.
//   One request is worked on at a time; in_req.ready is high only while idle
//   and the result register is free or being drained.
//   Reset empties the store (count to zero), sets num_clusters to 1 and
//   radius to 0. A stalled receiver holds the result register and the row;
//   nothing is dropped.
// ----------------------------------------------------------------------------
module radius_neighbor_count_nearest_unit #(
  parameter int unsigned MAX_POINTS   = rnc_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_CLUSTERS = rnc_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rnc_in_if.sink                    in_req,
  rnc_out_if.source                 out_res,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [rnc_pkg::RAD_W-1:0] cfg_wdata
);

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned QW  = (CW > rnc_pkg::QIX_W) ? CW : rnc_pkg::QIX_W;
  localparam int unsigned NC  = (MAX_CLUSTERS < 16) ? MAX_CLUSTERS : 16;
  localparam int unsigned DRN = NC + 3;
  localparam int unsigned CRD = rnc_pkg::CRD_W;
  localparam int unsigned TW  = rnc_pkg::TYP_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ORG   = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_ROOT  = 3'd5;

  // configuration
  logic [rnc_pkg::NCL_W-1:0] ncl_r;
  logic [rnc_pkg::RAD_W-1:0] rad_r;
  logic [2*rnc_pkg::RAD_W-1:0] r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncl_r <= rnc_pkg::NCL_W'(1);
      rad_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        rnc_pkg::CFG_NUM_CLUSTERS: ncl_r <= cfg_wdata[rnc_pkg::NCL_W-1:0];
        rnc_pkg::CFG_RADIUS:       rad_r <= cfg_wdata;
        default: ;
      endcase
    end
    r2_r <= rad_r * rad_r;
  end

  // control state
  logic [2:0]                state_r, state_nxt;
  logic [CW-1:0]             pcnt_r, pcnt_nxt;
  logic [CW-1:0]             rdi_r, rdi_nxt;
  logic [AW-1:0]             q_r, q_nxt;
  logic [rnc_pkg::NCL_W-1:0] k_r, k_nxt, k_clamp;
  logic [TW-1:0]             ci_r, ci_nxt;
  logic [4:0]                drn_r, drn_nxt;
  logic                      out_vld_r, out_vld_nxt;
  rnc_pkg::res_t             res_r, res_nxt;

  logic                      acc_req, out_free, ci_last;
  logic [QW-1:0]             q_w;
  logic                      ram_we, iss, sq_start, sq_vld;
  logic [AW-1:0]             raddr;
  logic [rnc_pkg::PNT_W-1:0] wdata, rdata;
  logic [rnc_pkg::ROOT_W-1:0] sq_root;
  rnc_pkg::ctl_t             ctl;

  rnc_pkg::tok_t tok [NC+1];
  rnc_pkg::acc_t acc [NC+1];

  assign out_free = !out_vld_r || out_res.ready;
  assign in_req.ready = (state_r == ST_IDLE) && out_free;
  assign acc_req  = in_req.valid && in_req.ready;
  assign q_w      = QW'(in_req.query_index);
  assign ci_last  = ({1'b0, ci_r} + rnc_pkg::NCL_W'(1)) == k_r;

  always_comb begin
    if (ncl_r == '0) begin
      k_clamp = rnc_pkg::NCL_W'(1);
    end else if (ncl_r > rnc_pkg::NCL_W'(NC)) begin
      k_clamp = rnc_pkg::NCL_W'(NC);
    end else begin
      k_clamp = ncl_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pcnt_nxt    = pcnt_r;
    rdi_nxt     = rdi_r;
    q_nxt       = q_r;
    k_nxt       = k_r;
    ci_nxt      = ci_r;
    drn_nxt     = drn_r;
    out_vld_nxt = out_vld_r && !out_res.ready;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    iss         = 1'b0;
    sq_start    = 1'b0;
    ctl         = '0;
    raddr       = rdi_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        raddr = q_w[AW-1:0];
        if (acc_req) begin
          case (in_req.func)
            rnc_pkg::FUNC_LOAD: begin
              if (pcnt_r < CW'(MAX_POINTS)) begin
                ram_we   = 1'b1;
                pcnt_nxt = pcnt_r + CW'(1);
              end
            end
            rnc_pkg::FUNC_CLEAR: pcnt_nxt = '0;
            rnc_pkg::FUNC_QUERY: begin
              if (q_w >= QW'(pcnt_r)) begin
                // bad index: one error result
                res_nxt       = '0;
                res_nxt.error = 1'b1;
                res_nxt.last  = 1'b1;
                out_vld_nxt   = 1'b1;
              end else begin
                q_nxt     = q_w[AW-1:0];
                k_nxt     = k_clamp;
                ci_nxt    = '0;
                rdi_nxt   = '0;
                ctl.clr   = 1'b1;
                state_nxt = ST_ORG;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ORG: begin
        // origin word lands now; issue point zero
        iss       = 1'b1;
        rdi_nxt   = CW'(1);
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (rdi_r < pcnt_r) begin
          iss     = 1'b1;
          rdi_nxt = rdi_r + CW'(1);
        end else begin
          drn_nxt   = 5'(DRN);
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drn_r == '0) begin
          state_nxt = ST_START;
        end else begin
          drn_nxt = drn_r - 5'd1;
        end
      end
      ST_START: begin
        sq_start  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_vld && out_free) begin
          res_nxt.cluster        = ci_r;
          res_nxt.neighbor_count = acc[0].cnt;
          res_nxt.min_dist2      = acc[0].mind;
          res_nxt.min_dist       = sq_root;
          res_nxt.found          = acc[0].fnd;
          res_nxt.error          = 1'b0;
          res_nxt.last           = ci_last;
          out_vld_nxt            = 1'b1;
          ctl.shift              = 1'b1;
          ci_nxt                 = ci_r + TW'(1);
          state_nxt              = ci_last ? ST_IDLE : ST_START;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pcnt_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pcnt_r    <= pcnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
    rdi_r <= rdi_nxt;
    q_r   <= q_nxt;
    k_r   <= k_nxt;
    ci_r  <= ci_nxt;
    drn_r <= drn_nxt;
    res_r <= res_nxt;
  end

  // point store: {x, y, type}
  assign wdata = {in_req.point_x, in_req.point_y, in_req.point_cluster};

  rnc_ram #(
    .WIDTH (rnc_pkg::PNT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pcnt_r[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // candidate pipeline: read, square deltas, sum and compare
  logic [CRD-1:0]          ox_r, oy_r;
  logic                    v1_r, s1_r, v2_r, v3_r;
  logic [TW-1:0]           t2_r, t3_r;
  logic [rnc_pkg::SQ_W-1:0] sqx_r, sqy_r;
  logic [rnc_pkg::D2_W-1:0] d2_r, d2_sum;
  logic                    w3_r;
  logic signed [CRD:0]     dx, dy;
  logic signed [2*CRD+1:0] px, py;
  logic [CRD-1:0]          rx, ry;
  logic [TW-1:0]           rt;

  assign {rx, ry, rt} = rdata;
  assign dx = $signed({1'b0, rx}) - $signed({1'b0, ox_r});
  assign dy = $signed({1'b0, ry}) - $signed({1'b0, oy_r});
  assign px = dx * dx;
  assign py = dy * dy;
  assign d2_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= iss;
      // drop the origin itself and types beyond the reported range
      v2_r <= v1_r && !s1_r && ({1'b0, rt} < k_r);
      v3_r <= v2_r;
    end
    if (state_r == ST_ORG) begin
      ox_r <= rx;
      oy_r <= ry;
    end
    s1_r  <= (rdi_r[AW-1:0] == q_r);
    sqx_r <= px[rnc_pkg::SQ_W-1:0];
    sqy_r <= py[rnc_pkg::SQ_W-1:0];
    t2_r  <= rt;
    t3_r  <= t2_r;
    d2_r  <= d2_sum;
    w3_r  <= d2_sum <= {1'b0, r2_r};
  end

  assign tok[0].vld  = v3_r;
  assign tok[0].typ  = t3_r;
  assign tok[0].d2   = d2_r;
  assign tok[0].near = w3_r;
  assign acc[NC]     = '0;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    rnc_cell #(
      .ID (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1]),
      .acc_in  (acc[g+1]),
      .acc_out (acc[g])
    );
  end

  rnc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .din   (acc[0].mind),
    .vld   (sq_vld),
    .root  (sq_root)
  );

  assign out_res.valid          = out_vld_r;
  assign out_res.cluster        = res_r.cluster;
  assign out_res.neighbor_count = res_r.neighbor_count;
  assign out_res.min_dist2      = res_r.min_dist2;
  assign out_res.min_dist       = res_r.min_dist;
  assign out_res.found          = res_r.found;
  assign out_res.error          = res_r.error;
  assign out_res.last           = res_r.last;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= CW'(MAX_POINTS))
    else $error("point count above store depth");
  a_org_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ORG) |-> !out_vld_r)
    else $error("result pending when query walk starts");
  a_ci_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT) |-> ({1'b0, ci_r} < k_r))
    else $error("read-out index beyond cluster count");
  a_sq_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START) |=> !sq_vld)
    else $error("root valid right after start");
`endif

endmodule

FILE: rtl/rnc_ram.sv
// ----------------------------------------------------------------------------
// rnc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rnc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rnc_cell.sv
// ----------------------------------------------------------------------------
// rnc_cell: one cluster cell of the accumulation row
// Accumulate count and minimum for its own cluster type, pass the candidate
// on to the next cell, and shift results toward the head during read-out.
// ----------------------------------------------------------------------------
module rnc_cell #(
  parameter int unsigned ID = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rnc_pkg::ctl_t ctl,
  input  rnc_pkg::tok_t tok_in,
  output rnc_pkg::tok_t tok_out,
  input  rnc_pkg::acc_t acc_in,
  output rnc_pkg::acc_t acc_out
);

  rnc_pkg::tok_t tok_r;
  rnc_pkg::acc_t acc_r, acc_nxt;
  logic          hit;

  assign hit = tok_in.vld && (tok_in.typ == rnc_pkg::TYP_W'(ID));

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.shift) begin
      acc_nxt = acc_in;
    end else if (hit) begin
      if (tok_in.near && acc_r.cnt != rnc_pkg::CNT_SAT) begin
        acc_nxt.cnt = acc_r.cnt + rnc_pkg::CNT_W'(1);
      end
      if (!acc_r.fnd || tok_in.d2 < acc_r.mind) begin
        acc_nxt.mind = tok_in.d2;
      end
      acc_nxt.fnd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
      acc_r     <= '0;
    end else begin
      tok_r.vld <= tok_in.vld;
      acc_r     <= acc_nxt;
    end
    tok_r.typ  <= tok_in.typ;
    tok_r.d2   <= tok_in.d2;
    tok_r.near <= tok_in.near;
  end

  assign tok_out = tok_r;
  assign acc_out = acc_r;

endmodule

FILE: rtl/rnc_sqrt.sv
// ----------------------------------------------------------------------------
// rnc_sqrt: iterative square root in Q.8
// Restoring digit-by-digit root of din * 2^16, one result bit per cycle.
// ----------------------------------------------------------------------------
module rnc_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rnc_pkg::D2_W-1:0]    din,
  output logic                        vld,
  output logic [rnc_pkg::ROOT_W-1:0]  root
);

  localparam int unsigned RW = rnc_pkg::ROOT_W;
  localparam int unsigned VW = 2 * RW;
  localparam int unsigned MW = RW + 2;
  localparam int unsigned NW = $clog2(RW);

  logic [VW-1:0]        val_r;
  logic [MW-1:0]        rem_r;
  logic [RW-1:0]        root_r;
  logic [NW-1:0]        cnt_r;
  logic                 busy_r, vld_r;
  logic [MW+1:0]        rem_sh, trial;

  assign rem_sh = {rem_r, val_r[VW-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      vld_r  <= 1'b0;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b1;
    end
    if (start) begin
      val_r  <= VW'({din, 16'b0});
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= NW'(RW - 1);
    end else if (busy_r) begin
      val_r <= {val_r[VW-3:0], 2'b00};
      cnt_r <= cnt_r - NW'(1);
      if (rem_sh >= trial) begin
        rem_r  <= MW'(rem_sh - trial);
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= MW'(rem_sh);
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign vld  = vld_r;
  assign root = root_r;

endmodule

FILE: sim/radius_neighbor_count_nearest_unit_tb.sv
// ----------------------------------------------------------------------------
// radius_neighbor_count_nearest_unit_tb: self-checking bench for the unit
// Loads labelled points, clears the store and runs queries under several
// cluster-count and radius settings. A local predictor computes every
// per-cluster result, and each returned result is checked field by field.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module radius_neighbor_count_nearest_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DIR_ROWS    = 20;

  // one directed request; err_row marks a row whose result is an error
  typedef struct {
    logic [1:0]                func;
    logic [rnc_pkg::CRD_W-1:0] x;
    logic [rnc_pkg::CRD_W-1:0] y;
    logic [rnc_pkg::TYP_W-1:0] typ;
    logic [rnc_pkg::QIX_W-1:0] qix;
    bit                        err_row;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                      cfg_we;
  logic                      cfg_idx;
  logic [rnc_pkg::RAD_W-1:0] cfg_wdata;

  rnc_in_if  req_ch ();
  rnc_out_if res_ch ();

  radius_neighbor_count_nearest_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block: point store, fill level and both registers.
  logic [rnc_pkg::CRD_W-1:0] shadow_x   [rnc_pkg::MAX_POINTS_DEF];
  logic [rnc_pkg::CRD_W-1:0] shadow_y   [rnc_pkg::MAX_POINTS_DEF];
  logic [rnc_pkg::TYP_W-1:0] shadow_typ [rnc_pkg::MAX_POINTS_DEF];
  int unsigned               shadow_count;
  logic [rnc_pkg::NCL_W-1:0] shadow_ncl;
  logic [rnc_pkg::RAD_W-1:0] shadow_radius;

  rnc_pkg::res_t pending_results[$];

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned loads_sent, queries_sent, bad_queries_sent, clears_sent;
  int unsigned results_seen;
  bit          calm;  // no idling on either side while set
  int unsigned res_hold;

  // register settings for the random phases
  logic [rnc_pkg::NCL_W-1:0] ncl_set [7] = '{5'd16, 5'd0, 5'd31, 5'd4, 5'd2, 5'd1, 5'd9};
  logic [rnc_pkg::RAD_W-1:0] rad_set [7] = '{15'd32767, 15'd5, 15'd0, 15'd1000, 15'd40,
                                             15'd20000, 15'd300};
  int unsigned               span_set [7] = '{32767, 7, 7, 600, 60, 32767, 300};

  stim_t dir_tab [DIR_ROWS] = '{
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd0,    1'b1},  // empty store
    '{2'd3,                15'd1,     15'd1,     4'd1,  10'd1,    1'b0},  // unused code
    '{rnc_pkg::FUNC_LOAD,  15'd0,     15'd0,     4'd0,  10'd0,    1'b0},
    '{rnc_pkg::FUNC_LOAD,  15'd32767, 15'd32767, 4'd0,  10'd0,    1'b0},
    '{rnc_pkg::FUNC_LOAD,  15'd32767, 15'd0,     4'd15, 10'd0,    1'b0},  // type above K
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd0,    1'b0},  // widest distance
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd1,    1'b0},
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd2,    1'b0},
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd1023, 1'b1},
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd3,    1'b1},  // index == count
    '{rnc_pkg::FUNC_CLEAR, 15'd0,     15'd0,     4'd0,  10'd0,    1'b0},
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd0,    1'b1},  // after clear
    '{rnc_pkg::FUNC_LOAD,  15'd5,     15'd5,     4'd0,  10'd0,    1'b0},
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd0,    1'b0},  // no candidate
    '{rnc_pkg::FUNC_LOAD,  15'd5,     15'd5,     4'd0,  10'd0,    1'b0},  // duplicate
    '{rnc_pkg::FUNC_LOAD,  15'd8,     15'd9,     4'd0,  10'd0,    1'b0},
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd0,    1'b0},  // zero distance
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd2,    1'b0},
    '{rnc_pkg::FUNC_LOAD,  15'd21845, 15'd10922, 4'd10, 10'd0,    1'b0},
    '{rnc_pkg::FUNC_QUERY, 15'd0,     15'd0,     4'd0,  10'd3,    1'b0}
  };

  // Floor of sqrt(d2) in Q.8, found bit by bit from the top.
  function automatic logic [rnc_pkg::ROOT_W-1:0] root_q8(logic [rnc_pkg::D2_W-1:0] d2);
    longint unsigned            scaled;
    longint unsigned            trial;
    logic [rnc_pkg::ROOT_W-1:0] acc;
    scaled = longint'(d2) << 16;
    acc = '0;
    for (int b = rnc_pkg::ROOT_W - 1; b >= 0; b--) begin
      trial = longint'(acc | (24'd1 << b));
      if (trial * trial <= scaled) acc = acc | (24'd1 << b);
    end
    return acc;
  endfunction

  // Queue the per-cluster totals that a query from point qix produces.
  task automatic predict_neighbors(logic [rnc_pkg::QIX_W-1:0] qix);
    int unsigned     kc;
    longint          dx, dy;
    longint unsigned d2, r2;
    int unsigned     tally [16];
    longint unsigned best [16];
    bit              seen [16];
    rnc_pkg::res_t   r;
    if (qix >= shadow_count) begin
      r = '0;
      r.error = 1'b1;
      r.last  = 1'b1;
      pending_results.push_back(r);
      return;
    end
    // saturate the register into 1 .. 16
    kc = (shadow_ncl == 0) ? 1 : (shadow_ncl > 16) ? 16 : shadow_ncl;
    r2 = longint'(shadow_radius) * longint'(shadow_radius);
    for (int c = 0; c < 16; c++) begin
      tally[c] = 0;
      best[c]  = 0;
      seen[c]  = 1'b0;
    end
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (i == qix || shadow_typ[i] >= kc) continue;
      dx = longint'(shadow_x[i]) - longint'(shadow_x[qix]);
      dy = longint'(shadow_y[i]) - longint'(shadow_y[qix]);
      d2 = dx * dx + dy * dy;
      if (d2 <= r2 && tally[shadow_typ[i]] < 2047) tally[shadow_typ[i]]++;
      if (!seen[shadow_typ[i]] || d2 < best[shadow_typ[i]]) best[shadow_typ[i]] = d2;
      seen[shadow_typ[i]] = 1'b1;
    end
    for (int unsigned c = 0; c < kc; c++) begin
      r.cluster        = c[rnc_pkg::TYP_W-1:0];
      r.neighbor_count = tally[c][rnc_pkg::CNT_W-1:0];
      r.min_dist2      = best[c][rnc_pkg::D2_W-1:0];
      r.min_dist       = root_q8(best[c][rnc_pkg::D2_W-1:0]);
      r.found          = seen[c];
      r.error          = 1'b0;
      r.last           = (c + 1 == kc);
      pending_results.push_back(r);
    end
  endtask

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Present one request, hold it until accepted, then update the shadow.
  task automatic send_req(logic [1:0] func, logic [rnc_pkg::CRD_W-1:0] x,
                          logic [rnc_pkg::CRD_W-1:0] y, logic [rnc_pkg::TYP_W-1:0] typ,
                          logic [rnc_pkg::QIX_W-1:0] qix, bit err_row);
    int unsigned   gap;
    rnc_pkg::res_t r;
    req_ch.valid         <= 1'b1;
    req_ch.func          <= func;
    req_ch.point_x       <= x;
    req_ch.point_y       <= y;
    req_ch.point_cluster <= typ;
    req_ch.query_index   <= qix;
    do @(posedge clk); while (!req_ch.ready);
    case (func)
      rnc_pkg::FUNC_LOAD: begin
        loads_sent++;
        if (shadow_count < rnc_pkg::MAX_POINTS_DEF) begin
          shadow_x[shadow_count]   = x;
          shadow_y[shadow_count]   = y;
          shadow_typ[shadow_count] = typ;
          shadow_count++;
        end
      end
      rnc_pkg::FUNC_CLEAR: begin
        clears_sent++;
        shadow_count = 0;
      end
      rnc_pkg::FUNC_QUERY: begin
        queries_sent++;
        if (qix >= shadow_count) bad_queries_sent++;
        if (err_row) begin
          r = '0;
          r.error = 1'b1;
          r.last  = 1'b1;
          pending_results.push_back(r);
        end else begin
          predict_neighbors(qix);
        end
      end
      default: ;  // unused code: no effect
    endcase
    gap = draw_wait();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [rnc_pkg::RAD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rnc_pkg::CFG_NUM_CLUSTERS) shadow_ncl = data[rnc_pkg::NCL_W-1:0];
    else shadow_radius = data;
  endtask

  // Mostly loads followed by queries on what was loaded; some noise.
  task automatic run_phase(int unsigned n_items, int unsigned span, int unsigned top_typ);
    int unsigned               pick;
    logic [rnc_pkg::CRD_W-1:0] bx, by;
    bx = $urandom;
    by = $urandom;
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (shadow_count > 48 && pick < 60) pick = 60;
      if (pick < 55 || shadow_count == 0 && pick < 90) begin
        send_req(rnc_pkg::FUNC_LOAD, bx + rnc_pkg::CRD_W'($urandom_range(0, span)),
                 by + rnc_pkg::CRD_W'($urandom_range(0, span)),
                 rnc_pkg::TYP_W'($urandom_range(0, top_typ)),
                 rnc_pkg::QIX_W'($urandom), 1'b0);
      end else if (pick < 90) begin
        send_req(rnc_pkg::FUNC_QUERY, rnc_pkg::CRD_W'($urandom), rnc_pkg::CRD_W'($urandom),
                 rnc_pkg::TYP_W'($urandom),
                 rnc_pkg::QIX_W'($urandom_range(0, shadow_count - 1)), 1'b0);
      end else if (pick < 95) begin
        // index at or past the fill level
        send_req(rnc_pkg::FUNC_QUERY, rnc_pkg::CRD_W'($urandom), rnc_pkg::CRD_W'($urandom),
                 rnc_pkg::TYP_W'($urandom),
                 rnc_pkg::QIX_W'($urandom_range(shadow_count, 1023)), 1'b0);
      end else if (pick < 98) begin
        send_req(rnc_pkg::FUNC_CLEAR, rnc_pkg::CRD_W'($urandom), rnc_pkg::CRD_W'($urandom),
                 rnc_pkg::TYP_W'($urandom), rnc_pkg::QIX_W'($urandom), 1'b0);
      end else begin
        send_req(2'd3, rnc_pkg::CRD_W'($urandom), rnc_pkg::CRD_W'($urandom),
                 rnc_pkg::TYP_W'($urandom), rnc_pkg::QIX_W'($urandom), 1'b0);
      end
    end
  endtask

  // Result side: stall at random after each accepted result, compare it.
  always @(posedge clk) begin
    rnc_pkg::res_t got, want;
    int unsigned   hold;
    if (!rst_n) begin
      res_ch.ready <= 1'b1;
      res_hold     <= 0;
    end else begin
      if (res_hold != 0) begin
        res_hold     <= res_hold - 1;
        res_ch.ready <= (res_hold == 1);
      end else if (res_ch.valid && res_ch.ready) begin
        hold          = draw_wait();
        res_hold     <= hold;
        res_ch.ready <= (hold == 0);
      end
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        got.cluster        = res_ch.cluster;
        got.neighbor_count = res_ch.neighbor_count;
        got.min_dist2      = res_ch.min_dist2;
        got.min_dist       = res_ch.min_dist;
        got.found          = res_ch.found;
        got.error          = res_ch.error;
        got.last           = res_ch.last;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: cluster %0d", got.cluster);
        end else begin
          want = pending_results.pop_front();
          if (got.cluster !== want.cluster || got.neighbor_count !== want.neighbor_count ||
              got.min_dist2 !== want.min_dist2 || got.min_dist !== want.min_dist ||
              got.found !== want.found || got.error !== want.error ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: cl %0d cnt %0d d2 %0d d %0d fnd %0b err %0b last %0b",
                       want.cluster, want.neighbor_count, want.min_dist2, want.min_dist,
                       want.found, want.error, want.last);
              $display("         got: cl %0d cnt %0d d2 %0d d %0d fnd %0b err %0b last %0b",
                       got.cluster, got.neighbor_count, got.min_dist2, got.min_dist,
                       got.found, got.error, got.last);
            end
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("radius_neighbor_count_nearest_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    loads_sent = 0;
    queries_sent = 0;
    bad_queries_sent = 0;
    clears_sent = 0;
    calm = 1'b0;
    shadow_count  = 0;
    shadow_ncl    = 5'd1;
    shadow_radius = '0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= rnc_pkg::CFG_NUM_CLUSTERS;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.func <= rnc_pkg::FUNC_LOAD;
    req_ch.point_x <= '0;
    req_ch.point_y <= '0;
    req_ch.point_cluster <= '0;
    req_ch.query_index <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: one cluster, radius zero.
    for (int unsigned i = 0; i < DIR_ROWS; i++)
      send_req(dir_tab[i].func, dir_tab[i].x, dir_tab[i].y, dir_tab[i].typ,
               dir_tab[i].qix, dir_tab[i].err_row);
    drain_results();

    // Random phases, one register setting each; the upper data bits of the
    // cluster register get random junk to show they are dropped.
    for (int p = 0; p < 7; p++) begin
      write_reg(rnc_pkg::CFG_NUM_CLUSTERS, {10'($urandom), ncl_set[p]});
      write_reg(rnc_pkg::CFG_RADIUS, (p == 6) ? rnc_pkg::RAD_W'($urandom) : rad_set[p]);
      calm = (p == 3);
      if (p % 2 == 1) send_req(rnc_pkg::FUNC_CLEAR, '0, '0, '0, '0, 1'b0);
      run_phase(15, span_set[p], (p == 4) ? 15 : ncl_set[p] + 1);
      drain_results();
    end

    $display("covered %0d loads, %0d queries (%0d bad index), %0d clears",
             loads_sent, queries_sent, bad_queries_sent, clears_sent);
    $display("checked %0d results over the reset setting and 7 register settings",
             results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("radius_neighbor_count_nearest_unit_tb: clean");
    end else begin
      $display("radius_neighbor_count_nearest_unit_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rnc_pkg.sv
rtl/rnc_if.sv
rtl/rnc_ram.sv
rtl/rnc_cell.sv
rtl/rnc_sqrt.sv
rtl/radius_neighbor_count_nearest_unit.sv
sim/radius_neighbor_count_nearest_unit_tb.sv
